[rtl/first_fit_free_list_allocator_macros.svh]
// assertion macros for the first-fit free list allocator
`ifndef FIRST_FIT_FREE_LIST_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_FREE_LIST_ALLOCATOR_MACROS_SVH
`ifndef SYNTH
`define FFA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define FFA_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define FFA_ASSERT(lbl, prop, msg)
`define FFA_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

[rtl/ffa_pkg.sv]
// package: sizes, constants and sequencer states of the free list allocator
`default_nettype none
package ffa_pkg;
    localparam int HEAP_UNITS = 16384;
    localparam int UNIT_BYTES = 16;
    localparam int ADDR_W = $clog2(HEAP_UNITS);
    localparam int SIZE_W = 15;
    localparam int BYTES_W = 18;
    localparam int UB_SHIFT = $clog2(UNIT_BYTES);
    localparam int WALK_LIMIT = 2 * HEAP_UNITS + 4;
    localparam int STEP_W = $clog2(WALK_LIMIT + 1);
    localparam int SUM_W = SIZE_W + 1;
    localparam logic [SIZE_W-1:0] GROW_MIN_RESET = SIZE_W'(4096);

    typedef enum logic [3:0] {
        S_IDLE,
        S_AL_FIRST,
        S_AL_CHK,
        S_AL_SPLIT,
        S_RL_WALK,
        S_RL_BP,
        S_RL_Q,
        S_RL_P
    } t_state;
endpackage
`default_nettype wire

[rtl/first_fit_free_list_allocator.sv]
// top level: first-fit free list heap allocator with next and size memories
//
// one request per transfer: start is taken when busy is low, and exactly one
// result comes back later on o_valid for a single cycle (the receiver cannot
// stall, so it must take it then). an allocate keeps busy high while it walks
// the free blocks from the rover, and while it splits a larger block. a free
// keeps busy high while it visits blocks to find its address-ordered slot and
// then writes the freed block and its neighbour. each heap extension adds a
// free of the new block. a free of address zero raises no busy. after a walk,
// the result strobe comes in the same cycle that busy falls. the next/size
// memories are read through a register: every list step is one memory read.
// the sentinel entry at unit 0 lives in flip-flops, so no clearing pass is
// needed after reset.
`default_nettype none
module first_fit_free_list_allocator import ffa_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               i_mode,
    input  wire logic [BYTES_W-1:0] i_request_bytes,
    input  wire logic [ADDR_W-1:0]  i_block_address,
    input  wire logic               i_grow_min_we,
    input  wire logic [SIZE_W-1:0]  i_grow_min,
    output logic                    o_valid,
    output logic [ADDR_W-1:0]       o_payload_address,
    output logic                    o_ok
);
`include "first_fit_free_list_allocator_macros.svh"

    // list store
    logic [ADDR_W-1:0] next_mem [HEAP_UNITS];
    logic [SIZE_W-1:0] size_mem [HEAP_UNITS];

    t_state r_state, n_state;

    logic [SIZE_W-1:0]  r_grow_min, r_need, r_psz, r_bsz, r_brk;
    logic [ADDR_W-1:0]  r_rover, r_p, r_prev, r_q, r_bp, r_bnx, r_p2;
    logic [ADDR_W-1:0]  r_next0, r_rd_next;
    logic [SIZE_W-1:0]  r_size0, r_rd_size;
    logic               r_rd_zero, r_from_alloc;
    logic [STEP_W-1:0]  r_steps, r_rsteps;
    logic               r_valid, r_ok;
    logic [ADDR_W-1:0]  r_payload;

    // memory port controls
    logic              rd_en, wr_nx_en, wr_sz_en;
    logic [ADDR_W-1:0] rd_addr, wr_addr, wr_nx;
    logic [SIZE_W-1:0] wr_sz;

    // finish controls
    logic              fin, fin_ok;
    logic [ADDR_W-1:0] fin_pay;

    logic              accept;
    logic [ADDR_W-1:0] rd_nx;
    logic [SIZE_W-1:0] rd_sz;
    logic [SIZE_W-1:0] req_need, grow, split_sz, nbsz;
    logic              fit, exact, at_rover, no_room, al_ovf, rl_ovf;
    logic              slot, mrg_q, mrg_p;
    logic [ADDR_W-1:0] split_p, nbnx, p_nx;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);

    // sentinel entry bypasses the memory
    assign rd_nx = r_rd_zero ? r_next0 : r_rd_next;
    assign rd_sz = r_rd_zero ? r_size0 : r_rd_size;

    // header unit plus payload rounded up to whole units
    assign req_need = SIZE_W'(i_request_bytes >> UB_SHIFT)
                    + SIZE_W'(|i_request_bytes[UB_SHIFT-1:0]) + SIZE_W'(1);

    assign fit      = rd_sz >= r_need;
    assign exact    = rd_sz == r_need;
    assign at_rover = r_p == r_rover;
    assign grow     = (r_need < r_grow_min) ? r_grow_min : r_need;
    assign no_room  = ({1'b0, r_brk} + {1'b0, grow}) > SUM_W'(HEAP_UNITS);
    assign al_ovf   = r_steps >= STEP_W'(WALK_LIMIT);
    assign rl_ovf   = r_rsteps >= STEP_W'(WALK_LIMIT);
    assign split_sz = rd_sz - r_need;
    assign split_p  = r_p + ADDR_W'(split_sz);

    // address-ordered slot between p and q, or at the wrap point
    assign slot = (r_bp > r_p && r_bp < rd_nx)
               || (r_p >= rd_nx && (r_bp > r_p || r_bp < rd_nx));

    assign mrg_q = (SUM_W'(r_bp) + SUM_W'(r_bsz)) == SUM_W'(r_q);
    assign nbsz  = mrg_q ? r_bsz + rd_sz : r_bsz;
    assign nbnx  = mrg_q ? rd_nx : r_q;
    assign mrg_p = (SUM_W'(r_p) + SUM_W'(r_psz)) == SUM_W'(r_bp);
    assign p_nx  = mrg_p ? r_bnx : r_bp;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (!i_mode) begin
                        n_state = S_AL_FIRST;
                    end else if (i_block_address != '0) begin
                        n_state = S_RL_WALK;
                    end
                end
            end
            S_AL_FIRST: n_state = S_AL_CHK;
            S_AL_CHK: begin
                if (fit) begin
                    n_state = exact ? S_IDLE : S_AL_SPLIT;
                end else if (at_rover) begin
                    n_state = no_room ? S_IDLE : S_RL_WALK;
                end else if (al_ovf) begin
                    n_state = S_IDLE;
                end
            end
            S_AL_SPLIT: n_state = S_IDLE;
            S_RL_WALK: begin
                if (slot) begin
                    n_state = S_RL_BP;
                end else if (rl_ovf) begin
                    n_state = S_IDLE;
                end
            end
            S_RL_BP: n_state = S_RL_Q;
            S_RL_Q:  n_state = S_RL_P;
            S_RL_P: begin
                n_state = (r_from_alloc && !al_ovf) ? S_AL_CHK : S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // memory accesses and finish controls
    always_comb begin
        rd_en    = 1'b0;
        rd_addr  = r_rover;
        wr_nx_en = 1'b0;
        wr_sz_en = 1'b0;
        wr_addr  = r_p;
        wr_nx    = r_bp;
        wr_sz    = r_bsz;
        fin      = 1'b0;
        fin_ok   = 1'b0;
        fin_pay  = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (!i_mode || i_block_address != '0) begin
                        rd_en = 1'b1;
                    end else begin
                        fin = 1'b1;
                    end
                end
            end
            S_AL_FIRST: begin
                rd_en   = 1'b1;
                rd_addr = rd_nx;
            end
            S_AL_CHK: begin
                if (fit) begin
                    if (exact) begin
                        wr_nx_en = 1'b1;
                        wr_addr  = r_prev;
                        wr_nx    = rd_nx;
                        fin      = 1'b1;
                        fin_ok   = 1'b1;
                        fin_pay  = r_p + ADDR_W'(1);
                    end else begin
                        wr_sz_en = 1'b1;
                        wr_addr  = r_p;
                        wr_sz    = split_sz;
                    end
                end else if (at_rover) begin
                    if (no_room) begin
                        fin = 1'b1;
                    end else begin
                        // new block header at the old break, then free it
                        wr_sz_en = 1'b1;
                        wr_addr  = ADDR_W'(r_brk);
                        wr_sz    = grow;
                        rd_en    = 1'b1;
                        rd_addr  = r_rover;
                    end
                end else if (al_ovf) begin
                    fin = 1'b1;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = rd_nx;
                end
            end
            S_AL_SPLIT: begin
                wr_sz_en = 1'b1;
                wr_addr  = r_p2;
                wr_sz    = r_need;
                fin      = 1'b1;
                fin_ok   = 1'b1;
                fin_pay  = r_p2 + ADDR_W'(1);
            end
            S_RL_WALK: begin
                if (slot) begin
                    rd_en   = 1'b1;
                    rd_addr = r_bp;
                end else if (rl_ovf) begin
                    fin = 1'b1;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = rd_nx;
                end
            end
            S_RL_BP: begin
                rd_en   = 1'b1;
                rd_addr = r_q;
            end
            S_RL_Q: begin
                wr_nx_en = 1'b1;
                wr_sz_en = 1'b1;
                wr_addr  = r_bp;
                wr_nx    = nbnx;
                wr_sz    = nbsz;
            end
            S_RL_P: begin
                wr_nx_en = 1'b1;
                wr_sz_en = 1'b1;
                wr_addr  = r_p;
                wr_nx    = p_nx;
                wr_sz    = mrg_p ? r_psz + r_bsz : r_psz;
                if (!r_from_alloc) begin
                    fin    = 1'b1;
                    fin_ok = 1'b1;
                end else if (al_ovf) begin
                    fin = 1'b1;
                end else begin
                    // walk on from the new rover, its next word forwarded
                    rd_en   = 1'b1;
                    rd_addr = p_nx;
                end
            end
            default: begin
                fin = 1'b0;
            end
        endcase
    end

    // memory read, registered
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_next <= next_mem[rd_addr];
            r_rd_size <= size_mem[rd_addr];
            r_rd_zero <= (rd_addr == '0);
        end
    end

    // memory write, sentinel goes to flip-flops
    always_ff @(posedge i_clk) begin
        if (wr_nx_en && wr_addr != '0) begin
            next_mem[wr_addr] <= wr_nx;
        end
        if (wr_sz_en && wr_addr != '0) begin
            size_mem[wr_addr] <= wr_sz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_next0    <= '0;
            r_size0    <= '0;
            r_rover    <= '0;
            r_brk      <= SIZE_W'(1);
            r_grow_min <= GROW_MIN_RESET;
            r_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= fin;
            if (i_grow_min_we) begin
                r_grow_min <= i_grow_min;
            end
            if (wr_nx_en && wr_addr == '0) begin
                r_next0 <= wr_nx;
            end
            if (wr_sz_en && wr_addr == '0) begin
                r_size0 <= wr_sz;
            end
            if (r_state == S_AL_CHK && !fit && at_rover && !no_room) begin
                r_brk <= r_brk + grow;
            end
            if ((r_state == S_AL_CHK && fit && exact) || r_state == S_AL_SPLIT) begin
                r_rover <= r_prev;
            end
            if (r_state == S_RL_P) begin
                r_rover <= r_p;
            end
        end
    end

    // walk datapath
    always_ff @(posedge i_clk) begin
        if (fin) begin
            r_ok      <= fin_ok;
            r_payload <= fin_pay;
        end
        case (r_state)
            S_IDLE: begin
                r_need       <= req_need;
                r_bp         <= i_block_address - ADDR_W'(1);
                r_prev       <= r_rover;
                r_p          <= r_rover;
                r_steps      <= '0;
                r_rsteps     <= '0;
                r_from_alloc <= 1'b0;
            end
            S_AL_FIRST: begin
                r_p <= rd_nx;
            end
            S_AL_CHK: begin
                if (fit) begin
                    r_p2 <= split_p;
                end else if (at_rover) begin
                    r_bp         <= ADDR_W'(r_brk);
                    r_p          <= r_rover;
                    r_rsteps     <= '0;
                    r_from_alloc <= 1'b1;
                end else begin
                    r_prev  <= r_p;
                    r_p     <= rd_nx;
                    r_steps <= r_steps + STEP_W'(1);
                end
            end
            S_RL_WALK: begin
                if (slot) begin
                    r_q   <= rd_nx;
                    r_psz <= rd_sz;
                end else begin
                    r_p      <= rd_nx;
                    r_rsteps <= r_rsteps + STEP_W'(1);
                end
            end
            S_RL_BP: begin
                r_bsz <= rd_sz;
            end
            S_RL_Q: begin
                r_bsz <= nbsz;
                r_bnx <= nbnx;
            end
            S_RL_P: begin
                r_prev  <= r_p;
                r_p     <= p_nx;
                r_steps <= r_steps + STEP_W'(1);
            end
            default: begin
                r_p <= r_p;
            end
        endcase
    end

    assign o_valid           = r_valid;
    assign o_ok              = r_ok;
    assign o_payload_address = r_payload;

    `FFA_ASSERT_NEXT(a_walk_starts, accept && !fin, busy, "accepted request did not start a walk")
    `FFA_ASSERT(a_break_bound, (r_brk <= SIZE_W'(HEAP_UNITS)), "heap break beyond heap")
    `FFA_ASSERT(a_grant_ok, (o_valid && o_payload_address != '0) |-> o_ok, "grant without ok")
endmodule
`default_nettype wire
